/* sv/dmpt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Direct-mapped position table: shared package
// Sizes, field layout, operation codes, controller states and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dmpt_pkg;

    // The slot count is a power of two, so the slot of a key is its low bits.
    localparam int unsigned TABLE_ENTRIES = 1024;
    localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned DEPTH_W = 7;
    localparam int unsigned SCORE_W = 16;
    localparam int unsigned BOUND_W = 2;
    localparam int unsigned MOVE_W  = 32;
    localparam int unsigned MODE_W  = 2;

    localparam int unsigned S_TDATA_W = 128;
    localparam int unsigned M_TDATA_W = 64;

    typedef enum logic [MODE_W-1:0] {
        MODE_PROBE = 2'd0,
        MODE_STORE = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_RESPOND
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic [DEPTH_W-1:0]        depth;
        logic signed [SCORE_W-1:0] score;
        logic [BOUND_W-1:0]        bound;
        logic [MOVE_W-1:0]         move;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic sweep;
        logic respond;
    } dp_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic out_free;
        logic in_clear;
    } dp_status_t;

endpackage
`default_nettype wire

/* sv/dmpt_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Direct-mapped position table: datapath
// Slot memory, request and read-data registers, sweep counter for clearing,
// replacement decision and the registered result stage.
// ----------------------------------------------------------------------------
module dmpt_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // s_tdata: key, search_depth, score, bound_kind, move_code (from bit 0)
    input  wire logic [dmpt_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: mode
    input  wire logic [dmpt_pkg::MODE_W-1:0]    s_tuser,
    input  wire dmpt_pkg::dp_cmd_t              cmd,
    output dmpt_pkg::dp_status_t                sts,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata: hit, found_depth, found_score, found_bound, found_move, written
    output logic [dmpt_pkg::M_TDATA_W-1:0]      m_tdata
);
    import dmpt_pkg::*;

    entry_t                 mem [TABLE_ENTRIES];
    entry_t                 in_entry;
    entry_t                 req_reg;
    entry_t                 rd_reg;
    entry_t                 wr_data;
    mode_t                  mode_reg;
    logic [IDX_W-1:0]       sweep_reg;
    logic [IDX_W-1:0]       sweep_next;
    logic [IDX_W-1:0]       wr_addr;
    logic                   wr_en;
    logic                   key_eq;
    logic                   take;
    logic                   hit;
    logic                   written;
    entry_t                 found;
    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic [M_TDATA_W-1:0]   m_tdata_next;

    assign in_entry.key   = s_tdata[63:0];
    assign in_entry.depth = s_tdata[70:64];
    assign in_entry.score = s_tdata[86:71];
    assign in_entry.bound = s_tdata[88:87];
    assign in_entry.move  = s_tdata[120:89];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg  <= in_entry;
            mode_reg <= mode_t'(s_tuser);
        end
    end

    assign key_eq = (rd_reg.key == req_reg.key);
    assign take   = (rd_reg.key == '0) || key_eq || (req_reg.depth >= rd_reg.depth);

    always_comb begin
        hit     = 1'b0;
        written = 1'b0;
        unique case (mode_reg)
            MODE_PROBE: begin
                hit = key_eq;
            end
            MODE_STORE: begin
                written = take;
            end
            MODE_CLEAR: begin
                written = 1'b1;
            end
            default: begin
                hit     = 1'b0;
                written = 1'b0;
            end
        endcase
    end

    assign found = hit ? rd_reg : '0;

    assign wr_en   = cmd.sweep || (cmd.respond && (mode_reg == MODE_STORE) && take);
    assign wr_addr = cmd.sweep ? sweep_reg : req_reg.key[IDX_W-1:0];
    assign wr_data = cmd.sweep ? '0 : req_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.capture) begin
            rd_reg <= mem[in_entry.key[IDX_W-1:0]];
        end
    end

    assign sts.sweep_last = (sweep_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign sts.out_free   = !m_tvalid_reg || m_tready;
    assign sts.in_clear   = (s_tuser == MODE_CLEAR);

    always_comb begin
        sweep_next = sweep_reg;
        if (cmd.sweep) begin
            sweep_next = sts.sweep_last ? '0 : sweep_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= '0;
        end else begin
            sweep_reg <= sweep_next;
        end
    end

    assign m_tdata_next = {5'b0, written, found.move, found.bound, found.score,
                           found.depth, hit};

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.respond) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.respond) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

/* sv/dmpt_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Direct-mapped position table: controller
// Sequences the clearing sweep after reset, request capture, the table-wide
// clear and the single result load with its conditional slot write.
// ----------------------------------------------------------------------------
module dmpt_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire dmpt_pkg::dp_status_t sts,
    output dmpt_pkg::dp_cmd_t         cmd
);
    import dmpt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = sts.in_clear ? ST_CLEAR : ST_RESPOND;
                end
            end
            ST_CLEAR: begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_RESPOND;
                end
            end
            ST_RESPOND: begin
                if (sts.out_free) begin
                    cmd.respond = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* sv/direct_mapped_position_table_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Direct-mapped position table
// A 1024-slot table of search results with depth-preferred replacement.
//
// Requests arrive on the s_ channel: mode in s_tuser (probe, store, clear),
// the key and entry fields in s_tdata. Each request yields one result on the
// m_ channel. The slot of a key is its low ten bits; a probe hits when the
// stored key matches, and a store replaces the slot when it is empty, holds
// the same key, or the new depth is at least the stored depth.
// A probe or store is accepted, the slot is read into a register in that
// cycle, and the result is loaded into the output register from the respond
// state once that register is free, which raises m_tvalid; the next request
// is accepted only after that load.
// A clear walks the memory one slot per cycle; its result is loaded once the
// sweep has reached the last slot and the output register is free, and no
// request is taken before that. After reset the same sweep zeroes every slot;
// s_tready stays low while it runs.
// A finished result sits in the output register; if the receiver stalls,
// the next request may still be accepted and read, and its result waits
// until the output register is free.
// ----------------------------------------------------------------------------
module direct_mapped_position_table_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata: key, search_depth, score, bound_kind, move_code (from bit 0)
    input  wire logic [dmpt_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: mode
    input  wire logic [dmpt_pkg::MODE_W-1:0]       s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata: hit, found_depth, found_score, found_bound, found_move, written
    output logic [dmpt_pkg::M_TDATA_W-1:0]         m_tdata
);
    import dmpt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t sts;

    dmpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dmpt_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_one_request_in_flight: assert property (
        @(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> !s_tready
    ) else $error("request accepted while another is in flight");

    a_respond_shows_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        cmd.respond |=> m_tvalid
    ) else $error("result load did not raise m_tvalid");

    a_respond_needs_room: assert property (
        @(posedge aclk) disable iff (!aresetn)
        cmd.respond |-> sts.out_free
    ) else $error("result loaded over a pending result");

    a_no_capture_during_sweep: assert property (
        @(posedge aclk) disable iff (!aresetn)
        cmd.sweep |-> !cmd.capture && !cmd.respond
    ) else $error("request handled during a clearing sweep");

endmodule
`default_nettype wire
